/* rtl/stopgo_pkg.sv */
`timescale 1ns / 1ps
// Package for the stop-and-go bit generator: widths, seeding constants and
// the shift register clock and seed mix functions. No dependencies.
package stopgo_pkg;

    localparam int SEED_W  = 31;
    localparam int REG_W   = 51;
    localparam int SUM_W   = SEED_W + 1;
    localparam int TDATA_W = 8;

    typedef logic [REG_W-1:0]  t_lfsr;
    typedef logic [SEED_W-1:0] t_seed;

    localparam logic [SUM_W-1:0] C_OFF_ONE   = SUM_W'(32'h0111_1111);
    localparam logic [SUM_W-1:0] C_OFF_TWO   = SUM_W'(32'h0222_2222);
    localparam logic [SUM_W-1:0] C_OFF_THREE = SUM_W'(32'h0333_3333);
    localparam t_seed            C_SEED_RST  = SEED_W'(1);

    // Feedback enters bit 31 by OR with the right-shifted word.
    function automatic t_lfsr f_clk(input t_lfsr v, input int t0, input int t1,
                                    input int t2, input int t3, input int t4);
        logic  fb;
        t_lfsr r;
        fb    = v[t0] ^ v[t1] ^ v[t2] ^ v[t3] ^ v[t4] ^ v[0];
        r     = v >> 1;
        r[31] = r[31] | fb;
        return r;
    endfunction

    function automatic t_lfsr f_clk_one(input t_lfsr v);
        return f_clk(v, 31, 7, 9, 1, 0);
    endfunction

    function automatic t_lfsr f_clk_two(input t_lfsr v);
        return f_clk(v, 31, 27, 9, 21, 0);
    endfunction

    function automatic t_lfsr f_clk_three(input t_lfsr v);
        return f_clk(v, 31, 8, 19, 10, 3);
    endfunction

    function automatic t_lfsr f_mix(input t_seed s, input logic [SUM_W-1:0] off,
                                    input int shl, input int shr);
        logic [SUM_W-1:0] a;
        t_lfsr            w;
        a = {1'b0, s} + off;
        w = {{(REG_W-SUM_W){1'b0}}, a};
        return (w << shl) ^ (w >> shr) ^ {{(REG_W-SEED_W){1'b0}}, s};
    endfunction

endpackage

/* rtl/stop_and_go_bit_generator.sv */
`timescale 1ns / 1ps
// Top level of the stop-and-go keystream bit generator.
// Depends on stopgo_pkg.
//
// Usage:
// The slave stream carries one item per key bit; s_axis_tdata bit 0 is the
// restart flag, which reseeds all three shift registers from the seed
// register before the bit is made. The master stream returns one item per
// input item with the key bit in m_axis_tdata bit 0.
// The seed is written through the cfg channel, which is always ready, and
// takes effect at the next restart.
// Each key bit is registered before m_axis_tvalid. The generator steps once per
// accepted item, so one item per cycle is sustained while the receiver takes
// items; the single pass of seed mix and shift register clocks sets the cycle.
// Reset clears the shift registers, sets the seed to 1 and empties the
// output. Until the first restart the key bits are all zero.
// When the receiver stalls, one more item is taken into a skid register;
// s_axis_tready then drops until the receiver takes an item.
module stop_and_go_bit_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stopgo_pkg::SEED_W-1:0]    i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [stopgo_pkg::TDATA_W-1:0]   s_axis_tdata,   // [0] restart
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [stopgo_pkg::TDATA_W-1:0]   m_axis_tdata    // [0] key_bit
);
    import stopgo_pkg::*;

    t_seed r_seed;
    t_lfsr r_one, r_two, r_three;
    logic  r_held, r_prev;
    logic  r_out_valid, r_skid_valid;
    logic  r_out_bit, r_skid_bit;

    t_lfsr n_one, n_two, n_three;
    logic  n_held, n_prev, n_key;
    logic  n_out_valid, n_skid_valid, n_out_bit, n_skid_bit;

    t_lfsr w_warm_one, w_warm_two, w_warm_three;
    t_lfsr w_start_one, w_start_two, w_start_three;
    logic  w_start_prev, w_start_held;
    logic  w_accept, w_restart, w_out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tdata[0];
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W-1){1'b0}}, r_out_bit};

    always_comb begin
        w_warm_one    = f_clk_one(f_mix(r_seed, C_OFF_ONE, 13, 19));
        w_warm_two    = f_clk_two(f_mix(r_seed, C_OFF_TWO, 17, 15));
        w_warm_three  = f_clk_three(f_mix(r_seed, C_OFF_THREE, 19, 13));
        w_start_one   = w_restart ? w_warm_one   : r_one;
        w_start_two   = w_restart ? w_warm_two   : r_two;
        w_start_three = w_restart ? w_warm_three : r_three;
        w_start_prev  = w_restart ? w_warm_one[0] : r_prev;
        w_start_held  = w_restart ? w_warm_two[0] : r_held;

        n_one   = f_clk_one(w_start_one);
        n_two   = w_start_prev ? f_clk_two(w_start_two) : w_start_two;
        n_held  = w_start_prev ? n_two[0] : w_start_held;
        n_three = f_clk_three(w_start_three);
        n_prev  = n_one[0];
        n_key   = n_held ^ n_three[0];
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_bit    = r_out_bit;
        n_skid_bit   = r_skid_bit;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_bit    = r_skid_bit;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept;
                n_out_bit   = n_key;
            end
        end else if (w_accept) begin
            n_skid_valid = 1'b1;
            n_skid_bit   = n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed       <= C_SEED_RST;
            r_one        <= '0;
            r_two        <= '0;
            r_three      <= '0;
            r_held       <= 1'b0;
            r_prev       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (w_accept) begin
                r_one   <= n_one;
                r_two   <= n_two;
                r_three <= n_three;
                r_held  <= n_held;
                r_prev  <= n_prev;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bit  <= n_out_bit;
        r_skid_bit <= n_skid_bit;
    end

endmodule

/* rtl/stopgo_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the stop-and-go bit generator, bound to the top level.
// Depends on stopgo_pkg.
module stopgo_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [stopgo_pkg::TDATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [stopgo_pkg::TDATA_W-1:0]   m_axis_tdata
);
    import stopgo_pkg::*;

    logic r_seeded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready && s_axis_tdata[0]) begin
            r_seeded <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled output item changed.");

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled while output is empty.");

    a_unseeded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_seeded |-> m_axis_tdata[0] == 1'b0)
        else $error("Nonzero key bit before any restart.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[TDATA_W-1:1] == '0)
        else $error("Unused output bits are not zero.");

endmodule

bind stop_and_go_bit_generator stopgo_checker u_stopgo_checker (.*);

/* tb/sv/stopgo_checker.sv */
`timescale 1ns / 1ps
// Checker for the stop-and-go bit generator: watches the seed, input and output
// channels, predicts each key bit and compares it. Depends on stopgo_pkg.
module stopgo_scoreboard
    import stopgo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  t_seed              i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [TDATA_W-1:0] i_in_data,    // [0] restart
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [TDATA_W-1:0] i_out_data,   // [0] key_bit
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_bits_checked,
    output int                 o_reseeds
);

    localparam logic [31:0] OFFSET_ONE   = 32'h0111_1111;
    localparam logic [31:0] OFFSET_TWO   = 32'h0222_2222;
    localparam logic [31:0] OFFSET_THREE = 32'h0333_3333;

    t_seed seed_shadow;
    t_lfsr sr_one;
    t_lfsr sr_two;
    t_lfsr sr_three;
    logic  hold_two;
    logic  last_one;
    logic  key_bits_q[$];

    function automatic t_lfsr lfsr_shift(input t_lfsr v, input int t0, input int t1,
                                         input int t2, input int t3, input int t4);
        logic fb;
        fb = v[t0] ^ v[t1] ^ v[t2] ^ v[t3] ^ v[t4] ^ v[0];
        return (v >> 1) | (t_lfsr'(fb) << 31);
    endfunction

    function automatic t_lfsr seed_scramble(input t_seed s, input logic [31:0] offset,
                                            input int shl, input int shr);
        logic [31:0] sum;
        t_lfsr       w;
        sum = 32'(s) + offset;
        w   = t_lfsr'(sum);
        return (w << shl) ^ (w >> shr) ^ t_lfsr'(s);
    endfunction

    always @(posedge i_clk) begin : predict_and_check
        logic one_bit;
        logic want;
        if (!i_rst_n) begin
            seed_shadow    = C_SEED_RST;
            sr_one         = '0;
            sr_two         = '0;
            sr_three       = '0;
            hold_two       = 1'b0;
            last_one       = 1'b0;
            o_fail_count   = 0;
            o_bits_checked = 0;
            o_reseeds      = 0;
            key_bits_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                seed_shadow = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data[0]) begin
                    sr_one   = seed_scramble(seed_shadow, OFFSET_ONE, 13, 19);
                    sr_two   = seed_scramble(seed_shadow, OFFSET_TWO, 17, 15);
                    sr_three = seed_scramble(seed_shadow, OFFSET_THREE, 19, 13);
                    sr_one   = lfsr_shift(sr_one, 31, 7, 9, 1, 0);
                    last_one = sr_one[0];
                    sr_two   = lfsr_shift(sr_two, 31, 27, 9, 21, 0);
                    hold_two = sr_two[0];
                    sr_three = lfsr_shift(sr_three, 31, 8, 19, 10, 3);
                    o_reseeds++;
                end
                sr_one  = lfsr_shift(sr_one, 31, 7, 9, 1, 0);
                one_bit = sr_one[0];
                // Register two only advances when register one gave a 1 on its previous step.
                if (last_one) begin
                    sr_two   = lfsr_shift(sr_two, 31, 27, 9, 21, 0);
                    hold_two = sr_two[0];
                end
                sr_three = lfsr_shift(sr_three, 31, 8, 19, 10, 3);
                key_bits_q.push_back(hold_two ^ sr_three[0]);
                last_one = one_bit;
            end
            if (i_out_valid && i_out_ready) begin
                if (key_bits_q.size() == 0) begin
                    $error("key_bit: no item expected, got %0b", i_out_data[0]);
                    o_fail_count++;
                end else begin
                    want = key_bits_q.pop_front();
                    o_bits_checked++;
                    if (i_out_data[0] !== want) begin
                        $error("key_bit mismatch: expected %0b, got %0b", want,
                               i_out_data[0]);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = key_bits_q.size();
    end

endmodule

/* tb/sv/tb_stop_and_go_bit_generator.sv */
`timescale 1ns / 1ps
// Top of the stop-and-go bit generator testbench: clock, reset, seed writes and
// restart stimulus with bursty input and stalling output. Depends on stopgo_pkg,
// stopgo_scoreboard and the generator RTL.
module tb_stop_and_go_bit_generator;
    import stopgo_pkg::*;

    localparam int    RANDOM_PHASES    = 8;
    localparam int    ITEMS_PER_PHASE  = 229;
    localparam t_seed SEED_MAX         = {SEED_W{1'b1}};

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    t_seed              i_cfg_data     = '0;
    logic               s_axis_tvalid  = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata   = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready  = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    int          bits_checked;
    int          reseeds;
    int          items_sent  = 0;
    int          seed_writes = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_left     = 0;
    logic [1:0]  rx_mode     = 2'd0;
    logic [3:0]  rx_tick     = 4'd0;

    stop_and_go_bit_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    stopgo_scoreboard u_scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bits_checked (bits_checked),
        .o_reseeds      (reseeds)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches between always ready, coin flips, long stalls
    // and a fixed duty pattern.
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 4'd1;
        if (rx_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 60);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            2'd0: begin
                m_axis_tready <= 1'b1;
            end
            2'd1: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_axis_tready <= ($urandom_range(0, 4) == 0);
            end
            default: begin
                m_axis_tready <= (rx_tick[1:0] != 2'd0);
            end
        endcase
    end

    task automatic send_item(input logic restart);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W-1){1'b0}}, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send_pattern(input logic [31:0] restarts, input int count);
        for (int i = 0; i < count; i++) begin
            send_item(restarts[i]);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_seed(input t_seed value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seed_writes++;
    endtask

    initial begin
        t_seed seed;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset seed: zero stream before any restart, then a restart.
        send_pattern(32'b0_0000_1000, 9);
        wait_idle();
        // Smallest seed with back-to-back restarts.
        write_seed('0);
        send_pattern(32'b11_0001, 6);
        wait_idle();
        // Largest seed, written before the stream; its single restart picks it up.
        write_seed(SEED_MAX);
        send_pattern(32'b000_0100, 7);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0: seed = '0;
                1: seed = SEED_MAX;
                2: seed = 'x;
                default: seed = t_seed'($urandom());
            endcase
            if (!$isunknown(seed)) begin
                write_seed(seed);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i == 0) begin
                    send_item($urandom_range(0, 3) != 0);
                end else begin
                    send_item($urandom_range(0, 49) == 0);
                end
            end
            wait_idle();
        end

        repeat (5) @(posedge i_clk);
        $display("Summary: %0d items sent, %0d key bits checked, %0d reseeds.",
                 items_sent, bits_checked, reseeds);
        $display("Summary: %0d seed writes, extremes included, under bursty input and stalls.",
                 seed_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d key bits still outstanding.", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
rtl/stopgo_pkg.sv
rtl/stop_and_go_bit_generator.sv
rtl/stopgo_checker.sv
tb/sv/stopgo_checker.sv
tb/sv/tb_stop_and_go_bit_generator.sv
